// ----- sv/edt_pkg.sv -----
// Shared types and constants for the edit distance block.
`timescale 1ns / 1ps

package edt_pkg;

	localparam int MAX_LEN_DEF = 32;
	localparam int DIST_W = 6;
	localparam logic [DIST_W-1:0] DIST_MAX = 6'd63;

	typedef enum logic [1:0] {
		CMD_SOURCE = 2'd0,
		CMD_TARGET = 2'd1,
		CMD_RUN    = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SROW,
		ST_RSTART,
		ST_CELL
	} state_t;

endpackage

// ----- sv/edt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module edt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/edit_distance_with_transposition.sv -----
// Top level: string loader and optimal string alignment distance engine.
//
// channel   direction  handshake            payload
// request   in         start & !busy        command, character
// result    out        done (one cycle)     distance, too_long
//
// A load request is handled as it is accepted. A run request on two
// non-empty strings walks the table row by row: ST_SROW, ST_RSTART, then
// ST_CELL across every target column, for each source row. An empty string
// answers on the next cycle. Reset clears lengths, flag and control; the
// RAMs need no clearing. The receiver cannot stall; done lasts one cycle.
`timescale 1ns / 1ps

module edit_distance_with_transposition
	import edt_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        command,
	input  logic [7:0]        character,
	output logic              done,
	output logic [DIST_W-1:0] distance,
	output logic              too_long
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int EW = (CW > DIST_W) ? CW : DIST_W;

	state_t state_q, state_d;

	logic [CW-1:0] src_len_q, tgt_len_q;
	logic          ovf_q;
	logic [CW-1:0] row_q, col_q;
	logic          sel_q;
	logic [7:0]    s_q, sp_q, tp_q;
	logic [CW-1:0] cur_prev_q, r1_prev_q, r2_m1_q, r2_m2_q;
	logic          done_q, too_long_q;
	logic [DIST_W-1:0] distance_q;

	logic          accept;
	logic          src_we, tgt_we;
	logic [AW-1:0] src_raddr, col_addr, wr_addr;
	logic [7:0]    src_rdata, tgt_rdata;
	logic          ram_a_we, ram_b_we;
	logic [CW-1:0] ram_a_rdata, ram_b_rdata;

	logic [CW-1:0] r1, r2, score;
	logic [7:0]    t;
	logic [CW:0]   cost, c_up, c_left, c_diag, c_swap, c_min;
	logic          swap_ok, last_col, last_row;
	logic [EW-1:0] score_ext, len_ext;
	logic [DIST_W-1:0] score_sat, len_sat;

	assign accept = start && !busy;
	assign last_col = (col_q == tgt_len_q);
	assign last_row = (row_q == src_len_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd_t'(command) == CMD_RUN && src_len_q != '0
						&& tgt_len_q != '0) begin
					state_d = ST_SROW;
				end
			end
			ST_SROW:   state_d = ST_RSTART;
			ST_RSTART: state_d = ST_CELL;
			ST_CELL: begin
				if (last_col) begin
					state_d = last_row ? ST_IDLE : ST_SROW;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = 1'b1;
		src_we    = 1'b0;
		tgt_we    = 1'b0;
		src_raddr = src_len_q[AW-1:0];
		col_addr  = tgt_len_q[AW-1:0];
		ram_a_we  = 1'b0;
		ram_b_we  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy   = 1'b0;
				src_we = accept && cmd_t'(command) == CMD_SOURCE && src_len_q < CW'(MAX_LEN);
				tgt_we = accept && cmd_t'(command) == CMD_TARGET && tgt_len_q < CW'(MAX_LEN);
			end
			ST_SROW: begin
				src_raddr = AW'(row_q - CW'(1));
			end
			ST_RSTART: begin
				col_addr = '0;
			end
			ST_CELL: begin
				col_addr = col_q[AW-1:0];
				ram_a_we = !sel_q;
				ram_b_we = sel_q;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign wr_addr = AW'(col_q - CW'(1));

	edt_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_src_ram (
		.clk   (clk),
		.we    (src_we),
		.waddr (src_len_q[AW-1:0]),
		.wdata (character),
		.raddr (src_raddr),
		.rdata (src_rdata)
	);

	edt_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_tgt_ram (
		.clk   (clk),
		.we    (tgt_we),
		.waddr (tgt_len_q[AW-1:0]),
		.wdata (character),
		.raddr (col_addr),
		.rdata (tgt_rdata)
	);

	edt_ram #(.WIDTH(CW), .DEPTH(MAX_LEN)) u_row_a_ram (
		.clk   (clk),
		.we    (ram_a_we),
		.waddr (wr_addr),
		.wdata (score),
		.raddr (col_addr),
		.rdata (ram_a_rdata)
	);

	edt_ram #(.WIDTH(CW), .DEPTH(MAX_LEN)) u_row_b_ram (
		.clk   (clk),
		.we    (ram_b_we),
		.waddr (wr_addr),
		.wdata (score),
		.raddr (col_addr),
		.rdata (ram_b_rdata)
	);

	// sel_q high: row A holds the previous row, row B the one before it
	always_comb begin
		t  = tgt_rdata;
		r1 = (row_q == CW'(1)) ? col_q : (sel_q ? ram_a_rdata : ram_b_rdata);
		r2 = (row_q == CW'(2)) ? col_q : (sel_q ? ram_b_rdata : ram_a_rdata);
		cost    = (s_q == t) ? '0 : (CW+1)'(1);
		c_up    = {1'b0, r1} + (CW+1)'(1);
		c_left  = {1'b0, cur_prev_q} + (CW+1)'(1);
		c_diag  = {1'b0, r1_prev_q} + cost;
		c_swap  = {1'b0, r2_m2_q} + cost;
		swap_ok = row_q > CW'(1) && col_q > CW'(1) && sp_q == t && s_q == tp_q;
		c_min   = (c_up < c_left) ? c_up : c_left;
		c_min   = (c_diag < c_min) ? c_diag : c_min;
		if (swap_ok && c_swap < c_min) begin
			c_min = c_swap;
		end
		score     = c_min[CW-1:0];
		score_ext = EW'(score);
		score_sat = (score_ext > EW'(DIST_MAX)) ? DIST_MAX : score_ext[DIST_W-1:0];
		len_ext   = EW'(src_len_q | tgt_len_q);
		len_sat   = (len_ext > EW'(DIST_MAX)) ? DIST_MAX : len_ext[DIST_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			src_len_q  <= '0;
			tgt_len_q  <= '0;
			ovf_q      <= 1'b0;
			done_q     <= 1'b0;
			row_q      <= '0;
			col_q      <= '0;
			sel_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd_t'(command))
							CMD_SOURCE: begin
								if (src_we) src_len_q <= src_len_q + CW'(1);
								else        ovf_q <= 1'b1;
							end
							CMD_TARGET: begin
								if (tgt_we) tgt_len_q <= tgt_len_q + CW'(1);
								else        ovf_q <= 1'b1;
							end
							CMD_RUN: begin
								row_q <= CW'(1);
								if (src_len_q == '0 || tgt_len_q == '0) begin
									done_q    <= 1'b1;
									src_len_q <= '0;
									tgt_len_q <= '0;
									ovf_q     <= 1'b0;
								end
							end
							default: begin
								ovf_q <= ovf_q;
							end
						endcase
					end
				end
				ST_RSTART: begin
					col_q <= CW'(1);
				end
				ST_CELL: begin
					col_q <= col_q + CW'(1);
					if (last_col) begin
						row_q <= row_q + CW'(1);
						sel_q <= !sel_q;
						if (last_row) begin
							done_q    <= 1'b1;
							src_len_q <= '0;
							tgt_len_q <= '0;
							ovf_q     <= 1'b0;
						end
					end
				end
				default: begin
					col_q <= col_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				distance_q <= len_sat;
				too_long_q <= ovf_q;
			end
			ST_RSTART: begin
				s_q        <= src_rdata;
				sp_q       <= s_q;
				cur_prev_q <= row_q;
				r1_prev_q  <= row_q - CW'(1);
				r2_m1_q    <= row_q - CW'(2);
			end
			ST_CELL: begin
				cur_prev_q <= score;
				r1_prev_q  <= r1;
				r2_m1_q    <= r2;
				r2_m2_q    <= r2_m1_q;
				tp_q       <= t;
				distance_q <= score_sat;
				too_long_q <= ovf_q;
			end
			default: begin
				tp_q <= tp_q;
			end
		endcase
	end

	assign done     = done_q;
	assign distance = distance_q;
	assign too_long = too_long_q;

endmodule
